// ----- rtl/core/u8u16_pkg.sv -----
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants of the UTF-8 to UTF-16 stream decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package u8u16_pkg;

  localparam logic [15:0] BOM_UNIT      = 16'hFEFF;
  localparam logic [15:0] HIGH_SURR     = 16'hD800;
  localparam logic [15:0] LOW_SURR      = 16'hDC00;
  localparam logic [20:0] SUPP_BASE     = 21'h010000;
  localparam logic [20:0] TWO_BYTE_MIN  = 21'h000080;
  localparam logic [20:0] THREE_BYTE_MIN = 21'h000800;
  localparam logic [20:0] BMP_MAX       = 21'h00FFFF;

  localparam logic [2:0] SEQ_LEN_2 = 3'd2;
  localparam logic [2:0] SEQ_LEN_3 = 3'd3;
  localparam logic [2:0] SEQ_LEN_4 = 3'd4;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        unit_valid;
    logic        bad_sequence;
    logic        final_result;
  } result_t;

  // results raised by one byte: count (0..2) and the two slots in order
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } decode_out_t;

  localparam result_t RES_NONE = '{code_unit: 16'h0000, unit_valid: 1'b0,
                                   bad_sequence: 1'b0, final_result: 1'b0};
  localparam result_t RES_ERROR = '{code_unit: 16'h0000, unit_valid: 1'b0,
                                    bad_sequence: 1'b1, final_result: 1'b1};
  localparam result_t RES_BARE_END = '{code_unit: 16'h0000, unit_valid: 1'b0,
                                       bad_sequence: 1'b0, final_result: 1'b1};

endpackage

`default_nettype wire

// ----- rtl/core/u8u16_stream_ifs.sv -----
// ----------------------------------------------------------------------------
// u8u16 stream interfaces
// Valid/ready channels for the byte input and the code unit output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface u8u16_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_string;

  modport source (output valid, output byte_in, output end_of_string, input ready);
  modport sink (input valid, input byte_in, input end_of_string, output ready);
endinterface

interface u8u16_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        unit_valid;
  logic        bad_sequence;
  logic        final_result;

  modport source (output valid, output code_unit, output unit_valid,
                  output bad_sequence, output final_result, input ready);
  modport sink (input valid, input code_unit, input unit_valid,
                input bad_sequence, input final_result, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/u8u16_decode.sv -----
// ----------------------------------------------------------------------------
// u8u16_decode
// Sequence state and per-byte decode: gathers code point bits, checks the
// sequence and produces up to two result transactions per byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u8u16_decode (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   step,
  input  wire logic [7:0]             byte_in,
  input  wire logic                   end_of_string,
  input  wire logic                   modified_mode,
  output u8u16_pkg::decode_out_t      dec_out
);
  import u8u16_pkg::*;

  logic [20:0] partial_value;
  logic [2:0]  sequence_length;
  logic [1:0]  bytes_pending;
  logic        at_string_start;
  logic        discarding;

  logic [20:0] partial_value_next;
  logic [2:0]  sequence_length_next;
  logic [1:0]  bytes_pending_next;
  logic        at_string_start_next;
  logic        discarding_next;

  logic [1:0]  pend_dec;
  logic [20:0] cont_bits;
  logic [20:0] merged;
  logic [20:0] item;
  logic [20:0] supp_off;
  logic        do_finish;
  logic        do_fail;
  logic        overlong;

  always_comb begin
    pend_dec = bytes_pending - 2'd1;
    unique case (pend_dec)
      2'd0:    cont_bits = {15'd0, byte_in[5:0]};
      2'd1:    cont_bits = {9'd0, byte_in[5:0], 6'd0};
      2'd2:    cont_bits = {3'd0, byte_in[5:0], 12'd0};
      default: cont_bits = {byte_in[2:0], 18'd0};
    endcase
    merged = partial_value | cont_bits;
    item = (bytes_pending == 2'd0) ? {13'd0, byte_in} : merged;
    supp_off = item - SUPP_BASE;

    unique case (sequence_length)
      SEQ_LEN_2: overlong = (merged < TWO_BYTE_MIN) &&
                            !(modified_mode && (merged == 21'd0));
      SEQ_LEN_3: overlong = merged < THREE_BYTE_MIN;
      SEQ_LEN_4: overlong = merged < SUPP_BASE;
      default:   overlong = 1'b0;
    endcase

    partial_value_next   = partial_value;
    sequence_length_next = sequence_length;
    bytes_pending_next   = bytes_pending;
    at_string_start_next = at_string_start;
    discarding_next      = discarding;
    dec_out.count  = 2'd0;
    dec_out.first  = RES_NONE;
    dec_out.second = RES_NONE;
    do_finish = 1'b0;
    do_fail   = 1'b0;

    if (discarding) begin
      if (end_of_string) begin
        at_string_start_next = 1'b1;
        discarding_next      = 1'b0;
      end
    end else if (bytes_pending == 2'd0) begin
      if (!byte_in[7]) begin
        if (modified_mode && (byte_in == 8'h00)) begin
          // zero terminator in modified mode
          dec_out.count = 2'd1;
          dec_out.first = RES_BARE_END;
          if (end_of_string) begin
            at_string_start_next = 1'b1;
          end else begin
            discarding_next = 1'b1;
          end
        end else begin
          do_finish = 1'b1;
        end
      end else if (byte_in[7:5] == 3'b110) begin
        partial_value_next   = {10'd0, byte_in[4:0], 6'd0};
        sequence_length_next = SEQ_LEN_2;
        bytes_pending_next   = 2'd1;
        do_fail              = end_of_string;
      end else if (byte_in[7:4] == 4'b1110) begin
        partial_value_next   = {5'd0, byte_in[3:0], 12'd0};
        sequence_length_next = SEQ_LEN_3;
        bytes_pending_next   = 2'd2;
        do_fail              = end_of_string;
      end else if ((byte_in[7:3] == 5'b11110) && !modified_mode) begin
        partial_value_next   = {byte_in[2:0], 18'd0};
        sequence_length_next = SEQ_LEN_4;
        bytes_pending_next   = 2'd3;
        do_fail              = end_of_string;
      end else begin
        do_fail = 1'b1;
      end
    end else if (byte_in[7:6] != 2'b10) begin
      do_fail = 1'b1;
    end else if (pend_dec != 2'd0) begin
      partial_value_next = merged;
      bytes_pending_next = pend_dec;
      do_fail            = end_of_string;
    end else if (overlong) begin
      do_fail = 1'b1;
    end else begin
      do_finish = 1'b1;
    end

    if (do_finish) begin
      if (at_string_start && (item == {5'd0, BOM_UNIT})) begin
        if (end_of_string) begin
          dec_out.count = 2'd1;
          dec_out.first = RES_BARE_END;
        end
      end else if (item > BMP_MAX) begin
        dec_out.count = 2'd2;
        dec_out.first = '{code_unit: HIGH_SURR + {5'd0, supp_off[20:10]},
                          unit_valid: 1'b1, bad_sequence: 1'b0, final_result: 1'b0};
        dec_out.second = '{code_unit: LOW_SURR + {6'd0, supp_off[9:0]},
                           unit_valid: 1'b1, bad_sequence: 1'b0,
                           final_result: end_of_string};
        at_string_start_next = 1'b0;
      end else begin
        dec_out.count = 2'd1;
        dec_out.first = '{code_unit: item[15:0], unit_valid: 1'b1,
                          bad_sequence: 1'b0, final_result: end_of_string};
        at_string_start_next = 1'b0;
      end
      partial_value_next   = '0;
      sequence_length_next = '0;
      bytes_pending_next   = '0;
      if (end_of_string) begin
        at_string_start_next = 1'b1;
      end
    end

    if (do_fail) begin
      dec_out.count        = 2'd1;
      dec_out.first        = RES_ERROR;
      partial_value_next   = '0;
      sequence_length_next = '0;
      bytes_pending_next   = '0;
      if (end_of_string) begin
        at_string_start_next = 1'b1;
        discarding_next      = 1'b0;
      end else begin
        discarding_next = 1'b1;
      end
    end

    if (!step) begin
      dec_out.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value   <= '0;
      sequence_length <= '0;
      bytes_pending   <= '0;
      at_string_start <= 1'b1;
      discarding      <= 1'b0;
    end else if (step) begin
      partial_value   <= partial_value_next;
      sequence_length <= sequence_length_next;
      bytes_pending   <= bytes_pending_next;
      at_string_start <= at_string_start_next;
      discarding      <= discarding_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/u8u16_out_fifo.sv -----
// ----------------------------------------------------------------------------
// u8u16_out_fifo
// Four-entry result queue: takes up to two results a cycle from the decoder
// and hands one result transaction a cycle out while the channel is ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u8u16_out_fifo (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire u8u16_pkg::decode_out_t dec_out,
  output logic                        room_for_two,
  u8u16_unit_if.source                units
);
  import u8u16_pkg::*;

  result_t     entries [4];
  logic [1:0]  wr_ptr;
  logic [1:0]  rd_ptr;
  logic [2:0]  count;
  logic        pop;
  result_t     head;

  assign pop          = units.valid && units.ready;
  assign room_for_two = count <= 3'd2;
  assign head         = entries[rd_ptr];

  assign units.valid        = count != 3'd0;
  assign units.code_unit    = head.code_unit;
  assign units.unit_valid   = head.unit_valid;
  assign units.bad_sequence = head.bad_sequence;
  assign units.final_result = head.final_result;

  always_ff @(posedge clk) begin
    if (dec_out.count != 2'd0) begin
      entries[wr_ptr] <= dec_out.first;
    end
    if (dec_out.count == 2'd2) begin
      entries[wr_ptr + 2'd1] <= dec_out.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + dec_out.count;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count + {1'b0, dec_out.count} - {2'b00, pop};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/utf8_to_utf16_stream_decoder_top.sv -----
// ----------------------------------------------------------------------------
// utf8_to_utf16_stream_decoder_top
// UTF-8 byte stream in, UTF-16 code units out, with error and end markers.
// ----------------------------------------------------------------------------
// One byte is accepted per clock: the byte is registered, decoded against the
// kept sequence state combinationally and its results pushed into a
// four-entry result queue, from which one result transaction leaves per
// clock. Between byte acceptance and the first result lie the input
// register and the result queue. A supplementary code point yields a
// surrogate pair; the rate is one byte per cycle while the output channel
// takes one result per cycle, and the input stalls only when the queue has
// fewer than two free entries. The user must write modified_mode through
// cfg_write/cfg_data only while the block is idle, which is not enforced.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_utf16_stream_decoder_top (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    cfg_write,
  input  wire logic    cfg_data,
  u8u16_byte_if.sink   bytes,
  u8u16_unit_if.source units
);
  import u8u16_pkg::*;

  logic        modified_mode;
  logic        stg_valid;
  logic [7:0]  stg_byte;
  logic        stg_eos;
  logic        room_for_two;
  logic        advance;
  decode_out_t dec_out;

  assign advance     = stg_valid && room_for_two;
  assign bytes.ready = !stg_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      modified_mode <= 1'b0;
    end else if (cfg_write) begin
      modified_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (bytes.ready) begin
      stg_valid <= bytes.valid;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      stg_byte <= bytes.byte_in;
      stg_eos  <= bytes.end_of_string;
    end
  end

  u8u16_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .byte_in       (stg_byte),
    .end_of_string (stg_eos),
    .modified_mode (modified_mode),
    .dec_out       (dec_out)
  );

  u8u16_out_fifo u_out_fifo (
    .clk          (clk),
    .rst          (rst),
    .dec_out      (dec_out),
    .room_for_two (room_for_two),
    .units        (units)
  );

endmodule

`default_nettype wire
